// ----- design/slerp2d_pkg.sv -----
// slerp2d_pkg: shared constants, CORDIC arctangent table and helpers for the 2D slerp block.
// No dependencies; every other file of the block but slerp2d_delay uses it.
package slerp2d_pkg;

  localparam int CompWidthDef   = 16;
  localparam int CordicStepsDef = 16;

  localparam int FracWidth  = 17;
  localparam int AngleWidth = 34;
  localparam int SinWidth   = 33;
  localparam int NumWidth   = 32;
  localparam int DivSteps   = 45;
  localparam int SerWidth   = 31;

  localparam logic [31:0] PiQ30      = 32'd3373259426;
  localparam logic [31:0] HalfPiQ30  = 32'd1686629713;
  localparam logic [31:0] TinyAngle  = 32'd11;
  localparam logic [31:0] SmallAngle = 32'd107374;
  localparam logic [31:0] SinFloor   = 32'd107374;
  localparam logic [31:0] NearPi     = PiQ30 - SmallAngle;

  localparam logic signed [SinWidth-1:0] CordicK = 33'sd652032874;

  localparam logic [FracWidth-1:0] OneQ16 = 17'h10000;

  localparam logic [29:0] AtanLow [10] = '{
    30'd843314857, 30'd497837830, 30'd263043837, 30'd133525159, 30'd67021687,
    30'd33543516,  30'd16775851,  30'd8388437,   30'd4194283,   30'd2097149
  };

  function automatic logic [AngleWidth-1:0] atan_step(input int i);
    logic [29:0] r;
    logic [3:0]  idx;
    idx = i[3:0];
    if (i < 10) begin
      r = AtanLow[idx];
    end else if (i <= 30) begin
      r = 30'd1 << (30 - i);
    end else begin
      r = '0;
    end
    return AngleWidth'(r);
  endfunction

endpackage

// ----- design/slerp2d_if.sv -----
// slerp2d_in_if / slerp2d_out_if: valid/ready channels for input and result words.
// Depends on slerp2d_pkg.
interface slerp2d_in_if #(
  parameter int COMPONENT_WIDTH = slerp2d_pkg::CompWidthDef
);
  logic                                 valid;
  logic                                 ready;
  logic signed [COMPONENT_WIDTH-1:0]    first_x;
  logic signed [COMPONENT_WIDTH-1:0]    first_y;
  logic signed [COMPONENT_WIDTH-1:0]    second_x;
  logic signed [COMPONENT_WIDTH-1:0]    second_y;
  logic [slerp2d_pkg::FracWidth-1:0]    fraction;

  modport source (output valid, first_x, first_y, second_x, second_y, fraction, input ready);
  modport sink   (input valid, first_x, first_y, second_x, second_y, fraction, output ready);
endinterface

interface slerp2d_out_if #(
  parameter int COMPONENT_WIDTH = slerp2d_pkg::CompWidthDef
);
  logic                              valid;
  logic                              ready;
  logic signed [COMPONENT_WIDTH-1:0] result_x;
  logic signed [COMPONENT_WIDTH-1:0] result_y;
  logic                              saturated;

  modport source (output valid, result_x, result_y, saturated, input ready);
  modport sink   (input valid, result_x, result_y, saturated, output ready);
endinterface

// ----- design/slerp2d_delay.sv -----
// slerp2d_delay: side-band word delay line with travelling valid bits.
// Depends on nothing; used by the top level to match unit latencies.
module slerp2d_delay #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);

  logic [WIDTH-1:0] data_q  [DEPTH];
  logic             valid_q [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_tap
    logic [WIDTH-1:0] dp;
    logic             vp;
    if (i == 0) begin : g_first
      assign dp = data_i;
      assign vp = valid_i;
    end else begin : g_next
      assign dp = data_q[i-1];
      assign vp = valid_q[i-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[i] <= 1'b0;
      end else if (en_i) begin
        valid_q[i] <= vp;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        data_q[i] <= dp;
      end
    end
  end

  assign valid_o = valid_q[DEPTH-1];
  assign data_o  = data_q[DEPTH-1];

endmodule

// ----- design/slerp2d_vec_cordic.sv -----
// slerp2d_vec_cordic: pipelined CORDIC vectoring, one step per stage, angle in Q30.
// Depends on slerp2d_pkg.
module slerp2d_vec_cordic #(
  parameter int VW    = 35,
  parameter int STEPS = 16
) (
  input  logic                                      clk_i,
  input  logic                                      en_i,
  input  logic signed [VW-1:0]                      x_i,
  input  logic signed [VW-1:0]                      y_i,
  input  logic signed [slerp2d_pkg::AngleWidth-1:0] z_i,
  output logic signed [slerp2d_pkg::AngleWidth-1:0] z_o
);
  import slerp2d_pkg::*;

  logic signed [VW-1:0]         x_q [STEPS];
  logic signed [VW-1:0]         y_q [STEPS];
  logic signed [AngleWidth-1:0] z_q [STEPS];

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic signed [VW-1:0]         xp, yp;
    logic signed [AngleWidth-1:0] zp, at;
    if (i == 0) begin : g_first
      assign xp = x_i;
      assign yp = y_i;
      assign zp = z_i;
    end else begin : g_next
      assign xp = x_q[i-1];
      assign yp = y_q[i-1];
      assign zp = z_q[i-1];
    end
    assign at = $signed(atan_step(i));

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (yp > 0) begin
          x_q[i] <= xp + (yp >>> i);
          y_q[i] <= yp - (xp >>> i);
          z_q[i] <= zp + at;
        end else begin
          x_q[i] <= xp - (yp >>> i);
          y_q[i] <= yp + (xp >>> i);
          z_q[i] <= zp - at;
        end
      end
    end
  end

  assign z_o = z_q[STEPS-1];

endmodule

// ----- design/slerp2d_sin_cordic.sv -----
// slerp2d_sin_cordic: range fold to [0, pi/2] then pipelined CORDIC rotation giving sin in Q30.
// Depends on slerp2d_pkg.
module slerp2d_sin_cordic #(
  parameter int STEPS = 16
) (
  input  logic                                    clk_i,
  input  logic                                    en_i,
  input  logic [31:0]                             p_i,
  output logic signed [slerp2d_pkg::SinWidth-1:0] sin_o
);
  import slerp2d_pkg::*;

  logic signed [AngleWidth-1:0] p0_q;
  logic signed [SinWidth-1:0]   x_q [STEPS];
  logic signed [SinWidth-1:0]   y_q [STEPS];
  logic signed [AngleWidth-1:0] p_q [STEPS];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p0_q <= $signed(AngleWidth'((p_i > HalfPiQ30) ? (PiQ30 - p_i) : p_i));
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic signed [SinWidth-1:0]   xp, yp;
    logic signed [AngleWidth-1:0] pp, at;
    if (i == 0) begin : g_first
      assign xp = CordicK;
      assign yp = '0;
      assign pp = p0_q;
    end else begin : g_next
      assign xp = x_q[i-1];
      assign yp = y_q[i-1];
      assign pp = p_q[i-1];
    end
    assign at = $signed(atan_step(i));

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (pp >= 0) begin
          x_q[i] <= xp - (yp >>> i);
          y_q[i] <= yp + (xp >>> i);
          p_q[i] <= pp - at;
        end else begin
          x_q[i] <= xp + (yp >>> i);
          y_q[i] <= yp - (xp >>> i);
          p_q[i] <= pp + at;
        end
      end
    end
  end

  assign sin_o = y_q[STEPS-1];

endmodule

// ----- design/slerp2d_divider.sv -----
// slerp2d_divider: pipelined restoring divider, one quotient bit per stage, num * 2^30 / den.
// Depends on slerp2d_pkg.
module slerp2d_divider (
  input  logic                                    clk_i,
  input  logic                                    en_i,
  input  logic signed [slerp2d_pkg::SinWidth-1:0] num_i,
  input  logic signed [slerp2d_pkg::SinWidth-1:0] den_i,
  output logic [slerp2d_pkg::DivSteps-1:0]        quot_o
);
  import slerp2d_pkg::*;

  logic [NumWidth-1:0] n_w;
  logic [NumWidth-1:0] d_w;

  logic [NumWidth-1:0] rem0_q, den0_q;
  logic [DivSteps-1:0] rest0_q;

  logic [NumWidth-1:0] rem_q  [DivSteps];
  logic [NumWidth-1:0] den_q  [DivSteps];
  logic [DivSteps-1:0] rest_q [DivSteps];
  logic [DivSteps-1:0] quot_q [DivSteps];

  assign n_w = (num_i < 0) ? '0 : num_i[NumWidth-1:0];
  assign d_w = (den_i < $signed({1'b0, SinFloor})) ? SinFloor : den_i[NumWidth-1:0];

  // quotient is known to fit DivSteps bits, so the top dividend bits seed the remainder
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem0_q  <= n_w >> (DivSteps - 30);
      rest0_q <= {n_w[DivSteps-31:0], 30'b0};
      den0_q  <= d_w;
    end
  end

  for (genvar k = 0; k < DivSteps; k++) begin : g_step
    logic [NumWidth-1:0] rp, dp;
    logic [DivSteps-1:0] sp, qp;
    logic [NumWidth:0]   sh;
    logic                ge;
    if (k == 0) begin : g_first
      assign rp = rem0_q;
      assign dp = den0_q;
      assign sp = rest0_q;
      assign qp = '0;
    end else begin : g_next
      assign rp = rem_q[k-1];
      assign dp = den_q[k-1];
      assign sp = rest_q[k-1];
      assign qp = quot_q[k-1];
    end
    assign sh = {rp, sp[DivSteps-1]};
    assign ge = sh >= {1'b0, dp};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? NumWidth'(sh - {1'b0, dp}) : sh[NumWidth-1:0];
        den_q[k]  <= dp;
        rest_q[k] <= sp << 1;
        quot_q[k] <= {qp[DivSteps-2:0], ge};
      end
    end
  end

  assign quot_o = quot_q[DivSteps-1];

endmodule

// ----- design/slerp_2d_interpolator.sv -----
// slerp_2d_interpolator: top level of the 2D spherical interpolator.
// Depends on slerp2d_pkg, slerp2d_if, slerp2d_delay, slerp2d_vec_cordic,
// slerp2d_sin_cordic and slerp2d_divider.
//
// Takes one word per clock (vectors a, b in signed Q2.14 and fraction s in Q1.16) and
// returns c = r0*a + r1*b with r = sin(s*t)/sin(t), t the angle between a and b. The
// pipeline never blocks on its own: one word enters and one leaves every cycle while the
// result side is ready; a stalled result holds the whole pipeline. The latency is set
// by the angle CORDIC, the sine CORDICs and the 45-stage ratio divider. saturated flags
// angles near pi or a clipped component; s = 0 and s = 1 return a and b exactly.
module slerp_2d_interpolator #(
  parameter int COMPONENT_WIDTH = slerp2d_pkg::CompWidthDef,
  parameter int CORDIC_STEPS    = slerp2d_pkg::CordicStepsDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  slerp2d_in_if.sink   in_i,
  slerp2d_out_if.source out_o
);
  import slerp2d_pkg::*;

  localparam int CW   = COMPONENT_WIDTH;
  localparam int PS   = (2 * CW > 60) ? (2 * CW - 60) : 0;
  localparam int VW   = 2 * CW - PS + 3;
  localparam int RS   = (CW > 16) ? (CW - 16) : 0;
  localparam int OF   = 30 - RS;
  localparam int RSW  = DivSteps + 1 - RS;
  localparam int MW   = RSW + CW;
  localparam int SUMW = MW + 2;

  localparam logic signed [SUMW-1:0] Half = SUMW'(1) << (OF - 1);
  localparam logic signed [SUMW-1:0] Hi   = {{(SUMW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [SUMW-1:0] Lo   = ~Hi;

  typedef struct packed {
    logic signed [CW-1:0]  ax;
    logic signed [CW-1:0]  ay;
    logic signed [CW-1:0]  bx;
    logic signed [CW-1:0]  by;
    logic [FracWidth-1:0]  fr;
  } base_t;

  typedef struct packed {
    base_t b;
    logic  crs_zero;
    logic  dot_neg;
  } vside_t;

  typedef struct packed {
    base_t                b;
    logic                 near;
    logic                 tiny;
    logic                 small_ang;
    logic [SerWidth-1:0]  ser1;
    logic [SerWidth-1:0]  ser0;
  } rside_t;

  logic en;

  // stage 1: products
  logic                   s1_v_q;
  base_t                  s1_b_q;
  logic signed [2*CW-1:0] s1_pxx_q, s1_pyy_q, s1_pxy_q, s1_pyx_q;

  // stage 2: dot, cross, CORDIC seed
  logic                         s2_v_q;
  vside_t                       s2_s_q;
  logic signed [VW-1:0]         s2_x_q, s2_y_q;
  logic signed [AngleWidth-1:0] s2_z_q;
  logic signed [VW-1:0]         dot_d, crs_d, crs_abs_d;

  logic                         d1_v;
  vside_t                       d1_s;
  logic signed [AngleWidth-1:0] vz;

  // stage 3: angle
  logic        s3_v_q;
  base_t       s3_b_q;
  logic        s3_near_q;
  logic [31:0] s3_t_q, t_d, tz_d;

  // stage 4: arguments, squares
  logic                 s4_v_q;
  base_t                s4_b_q;
  logic                 s4_near_q, s4_tiny_q, s4_small_q;
  logic [31:0]          s4_t_q, s4_arg1_q, s4_arg0_q;
  logic [33:0]          s4_tt_q, s4_ff1_q, s4_ff0_q;
  logic [FracWidth-1:0] g4;
  logic [48:0]          m1_d, m0_d;

  // stage 5: series products
  logic        s5_v_q;
  base_t       s5_b_q;
  logic        s5_near_q, s5_tiny_q, s5_small_q;
  logic [31:0] s5_t_q, s5_arg1_q, s5_arg0_q;
  logic [50:0] s5_v1_q, s5_v0_q;
  logic [33:0] om1_full, om0_full;

  logic [FracWidth-1:0] g5;
  logic [SerWidth-1:0]  a30_1, a30_0;
  logic [2:0]           c1, c0;
  logic [33:0]          mm1, mm0;
  rside_t               r_in;

  logic signed [SinWidth-1:0] sin1, sin0, sind;
  logic                       d2_v;
  rside_t                     d2_s;
  logic [DivSteps-1:0]        q1, q0;
  logic                       d3_v;
  rside_t                     d3_s;

  // stage 7: ratio select
  logic                  s7_v_q;
  base_t                 s7_b_q;
  logic                  s7_near_q;
  logic signed [RSW-1:0] s7_r1_q, s7_r0_q;
  logic [DivSteps-1:0]   sel1, sel0;
  logic [FracWidth-1:0]  g7;

  // stage 8: weighting products
  logic                 s8_v_q;
  base_t                s8_b_q;
  logic                 s8_near_q;
  logic signed [MW-1:0] s8_p0x_q, s8_p1x_q, s8_p0y_q, s8_p1y_q;

  // output register
  logic                 out_v_q;
  logic signed [CW-1:0] rx_q, ry_q;
  logic                 sat_q;
  logic signed [SUMW-1:0] sx, sy, cx, cy;
  logic signed [CW-1:0]   rx_d, ry_d;
  logic                   sat_d, clx, cly;

  assign en         = !out_v_q || out_o.ready;
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      s4_v_q  <= 1'b0;
      s5_v_q  <= 1'b0;
      s7_v_q  <= 1'b0;
      s8_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q  <= in_i.valid;
      s2_v_q  <= s1_v_q;
      s3_v_q  <= d1_v;
      s4_v_q  <= s3_v_q;
      s5_v_q  <= s4_v_q;
      s7_v_q  <= d3_v;
      s8_v_q  <= s7_v_q;
      out_v_q <= s8_v_q;
    end
  end

  // stage 1
  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_b_q.ax <= in_i.first_x;
      s1_b_q.ay <= in_i.first_y;
      s1_b_q.bx <= in_i.second_x;
      s1_b_q.by <= in_i.second_y;
      s1_b_q.fr <= (in_i.fraction > OneQ16) ? OneQ16 : in_i.fraction;
      s1_pxx_q  <= in_i.first_x * in_i.second_x;
      s1_pyy_q  <= in_i.first_y * in_i.second_y;
      s1_pxy_q  <= in_i.first_x * in_i.second_y;
      s1_pyx_q  <= in_i.first_y * in_i.second_x;
    end
  end

  // stage 2
  assign dot_d     = VW'(s1_pxx_q >>> PS) + VW'(s1_pyy_q >>> PS);
  assign crs_d     = VW'(s1_pxy_q >>> PS) - VW'(s1_pyx_q >>> PS);
  assign crs_abs_d = (crs_d < 0) ? -crs_d : crs_d;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_s_q.b        <= s1_b_q;
      s2_s_q.crs_zero <= (crs_d == '0);
      s2_s_q.dot_neg  <= (dot_d < 0);
      if (dot_d < 0) begin
        s2_x_q <= crs_abs_d;
        s2_y_q <= -dot_d;
        s2_z_q <= $signed(AngleWidth'(HalfPiQ30));
      end else begin
        s2_x_q <= dot_d;
        s2_y_q <= crs_abs_d;
        s2_z_q <= '0;
      end
    end
  end

  slerp2d_vec_cordic #(
    .VW    (VW),
    .STEPS (CORDIC_STEPS)
  ) u_vec (
    .clk_i (clk_i),
    .en_i  (en),
    .x_i   (s2_x_q),
    .y_i   (s2_y_q),
    .z_i   (s2_z_q),
    .z_o   (vz)
  );

  slerp2d_delay #(
    .WIDTH ($bits(vside_t)),
    .DEPTH (CORDIC_STEPS)
  ) u_dly_vec (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s2_v_q),
    .data_i  (s2_s_q),
    .valid_o (d1_v),
    .data_o  (d1_s)
  );

  // stage 3
  always_comb begin
    priority if (vz < 0) begin
      tz_d = '0;
    end else if (vz > $signed(AngleWidth'(PiQ30))) begin
      tz_d = PiQ30;
    end else begin
      tz_d = vz[31:0];
    end
    if (d1_s.crs_zero) begin
      t_d = d1_s.dot_neg ? PiQ30 : '0;
    end else begin
      t_d = tz_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_b_q    <= d1_s.b;
      s3_t_q    <= t_d;
      s3_near_q <= t_d > NearPi;
    end
  end

  // stage 4
  assign g4   = OneQ16 - s3_b_q.fr;
  assign m1_d = 49'(s3_b_q.fr) * 49'(s3_t_q);
  assign m0_d = 49'(g4) * 49'(s3_t_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_b_q     <= s3_b_q;
      s4_near_q  <= s3_near_q;
      s4_tiny_q  <= s3_t_q <= TinyAngle;
      s4_small_q <= s3_t_q < SmallAngle;
      s4_t_q     <= s3_t_q;
      s4_arg1_q  <= m1_d[47:16];
      s4_arg0_q  <= m0_d[47:16];
      s4_tt_q    <= 34'(s3_t_q[16:0]) * 34'(s3_t_q[16:0]);
      s4_ff1_q   <= 34'(s3_b_q.fr) * 34'(s3_b_q.fr);
      s4_ff0_q   <= 34'(g4) * 34'(g4);
    end
  end

  // stage 5
  assign om1_full = 34'h1_0000_0000 - s4_ff1_q;
  assign om0_full = 34'h1_0000_0000 - s4_ff0_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_b_q     <= s4_b_q;
      s5_near_q  <= s4_near_q;
      s5_tiny_q  <= s4_tiny_q;
      s5_small_q <= s4_small_q;
      s5_t_q     <= s4_t_q;
      s5_arg1_q  <= s4_arg1_q;
      s5_arg0_q  <= s4_arg0_q;
      s5_v1_q    <= 51'(s4_tt_q) * 51'(om1_full[32:16]);
      s5_v0_q    <= 51'(s4_tt_q) * 51'(om0_full[32:16]);
    end
  end

  // small-angle series, aligned with the sine units by the delay line
  // top bits stay below 12 over the small-angle range, so /6 is one compare
  assign g5    = OneQ16 - s5_b_q.fr;
  assign a30_1 = {s5_b_q.fr, 14'b0};
  assign a30_0 = {g5, 14'b0};
  assign c1    = (s5_v1_q[50:46] >= 5'd6) ? 3'd1 : 3'd0;
  assign c0    = (s5_v0_q[50:46] >= 5'd6) ? 3'd1 : 3'd0;
  assign mm1   = 34'(a30_1) * 34'(c1);
  assign mm0   = 34'(a30_0) * 34'(c0);

  always_comb begin
    r_in.b         = s5_b_q;
    r_in.near      = s5_near_q;
    r_in.tiny      = s5_tiny_q;
    r_in.small_ang = s5_small_q;
    r_in.ser1      = a30_1 + SerWidth'(mm1[33:30]);
    r_in.ser0      = a30_0 + SerWidth'(mm0[33:30]);
  end

  slerp2d_sin_cordic #(.STEPS (CORDIC_STEPS)) u_sin1 (
    .clk_i (clk_i),
    .en_i  (en),
    .p_i   (s5_arg1_q),
    .sin_o (sin1)
  );

  slerp2d_sin_cordic #(.STEPS (CORDIC_STEPS)) u_sin0 (
    .clk_i (clk_i),
    .en_i  (en),
    .p_i   (s5_arg0_q),
    .sin_o (sin0)
  );

  slerp2d_sin_cordic #(.STEPS (CORDIC_STEPS)) u_sind (
    .clk_i (clk_i),
    .en_i  (en),
    .p_i   (s5_t_q),
    .sin_o (sind)
  );

  slerp2d_delay #(
    .WIDTH ($bits(rside_t)),
    .DEPTH (CORDIC_STEPS + 1)
  ) u_dly_sin (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s5_v_q),
    .data_i  (r_in),
    .valid_o (d2_v),
    .data_o  (d2_s)
  );

  slerp2d_divider u_div1 (
    .clk_i  (clk_i),
    .en_i   (en),
    .num_i  (sin1),
    .den_i  (sind),
    .quot_o (q1)
  );

  slerp2d_divider u_div0 (
    .clk_i  (clk_i),
    .en_i   (en),
    .num_i  (sin0),
    .den_i  (sind),
    .quot_o (q0)
  );

  slerp2d_delay #(
    .WIDTH ($bits(rside_t)),
    .DEPTH (DivSteps + 1)
  ) u_dly_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (d2_v),
    .data_i  (d2_s),
    .valid_o (d3_v),
    .data_o  (d3_s)
  );

  // stage 7
  assign g7 = OneQ16 - d3_s.b.fr;

  always_comb begin
    priority if (d3_s.tiny) begin
      sel1 = DivSteps'({d3_s.b.fr, 14'b0});
      sel0 = DivSteps'({g7, 14'b0});
    end else if (d3_s.small_ang) begin
      sel1 = DivSteps'(d3_s.ser1);
      sel0 = DivSteps'(d3_s.ser0);
    end else begin
      sel1 = q1;
      sel0 = q0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s7_b_q    <= d3_s.b;
      s7_near_q <= d3_s.near;
      s7_r1_q   <= $signed(RSW'(sel1 >> RS));
      s7_r0_q   <= $signed(RSW'(sel0 >> RS));
    end
  end

  // stage 8
  always_ff @(posedge clk_i) begin
    if (en) begin
      s8_b_q    <= s7_b_q;
      s8_near_q <= s7_near_q;
      s8_p0x_q  <= s7_r0_q * s7_b_q.ax;
      s8_p1x_q  <= s7_r1_q * s7_b_q.bx;
      s8_p0y_q  <= s7_r0_q * s7_b_q.ay;
      s8_p1y_q  <= s7_r1_q * s7_b_q.by;
    end
  end

  // output stage: round, clip, end-point bypass
  assign sx  = SUMW'(s8_p0x_q) + SUMW'(s8_p1x_q) + Half;
  assign sy  = SUMW'(s8_p0y_q) + SUMW'(s8_p1y_q) + Half;
  assign cx  = sx >>> OF;
  assign cy  = sy >>> OF;
  assign clx = (cx > Hi) || (cx < Lo);
  assign cly = (cy > Hi) || (cy < Lo);

  always_comb begin
    priority if (s8_b_q.fr == '0) begin
      rx_d  = s8_b_q.ax;
      ry_d  = s8_b_q.ay;
      sat_d = 1'b0;
    end else if (s8_b_q.fr == OneQ16) begin
      rx_d  = s8_b_q.bx;
      ry_d  = s8_b_q.by;
      sat_d = 1'b0;
    end else begin
      rx_d  = (cx > Hi) ? CW'(Hi) : (cx < Lo) ? CW'(Lo) : CW'(cx);
      ry_d  = (cy > Hi) ? CW'(Hi) : (cy < Lo) ? CW'(Lo) : CW'(cy);
      sat_d = s8_near_q || clx || cly;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rx_q  <= rx_d;
      ry_q  <= ry_d;
      sat_q <= sat_d;
    end
  end

  assign out_o.valid     = out_v_q;
  assign out_o.result_x  = rx_q;
  assign out_o.result_y  = ry_q;
  assign out_o.saturated = sat_q;

endmodule
